### hw/rtl/jse_pkg.sv
// jse_pkg: shared types, character codes and escape text helpers for the
// json string escaper. No dependencies; used by every module of the block.

package jse_pkg;

    // configuration register indexes
    localparam logic [1:0] REG_ESCAPE_MODE = 2'd0;
    localparam logic [1:0] REG_LINE_SEP    = 2'd1;

    // escape modes
    localparam logic [1:0] MODE_PLAIN   = 2'd0;
    localparam logic [1:0] MODE_HTML    = 2'd1;
    localparam logic [1:0] MODE_RELAXED = 2'd2;
    localparam logic [1:0] MODE_UNSAFE  = 2'd3;

    // held prefix counts
    localparam logic [1:0] HELD_NONE = 2'd0;
    localparam logic [1:0] HELD_E2   = 2'd1;
    localparam logic [1:0] HELD_E280 = 2'd2;

    // character codes
    localparam logic [7:0] C_QUOTE   = 8'h22;
    localparam logic [7:0] C_AMP     = 8'h26;
    localparam logic [7:0] C_APOS    = 8'h27;
    localparam logic [7:0] C_SLASH   = 8'h2F;
    localparam logic [7:0] C_LT      = 8'h3C;
    localparam logic [7:0] C_GT      = 8'h3E;
    localparam logic [7:0] C_BSLASH  = 8'h5C;
    localparam logic [7:0] C_BS      = 8'h08;
    localparam logic [7:0] C_TAB     = 8'h09;
    localparam logic [7:0] C_LF      = 8'h0A;
    localparam logic [7:0] C_FF      = 8'h0C;
    localparam logic [7:0] C_CR      = 8'h0D;
    localparam logic [7:0] C_SPACE   = 8'h20;
    localparam logic [7:0] C_LOW_B   = 8'h62;
    localparam logic [7:0] C_LOW_F   = 8'h66;
    localparam logic [7:0] C_LOW_N   = 8'h6E;
    localparam logic [7:0] C_LOW_R   = 8'h72;
    localparam logic [7:0] C_LOW_T   = 8'h74;
    localparam logic [7:0] C_LOW_U   = 8'h75;
    localparam logic [7:0] C_DIG0    = 8'h30;
    localparam logic [7:0] C_DIG2    = 8'h32;
    localparam logic [7:0] C_DIG8    = 8'h38;
    localparam logic [7:0] C_DIG9    = 8'h39;
    localparam logic [7:0] C_UPPER_A = 8'h41;
    localparam logic [7:0] C_UTF_E2  = 8'hE2;
    localparam logic [7:0] C_UTF_80  = 8'h80;
    localparam logic [7:0] C_UTF_A8  = 8'hA8;
    localparam logic [7:0] C_UTF_A9  = 8'hA9;

    // entity texts, left aligned in eight bytes
    localparam logic [63:0] ENT_QUOT = {"&quot;", 16'h0};
    localparam logic [63:0] ENT_APOS = {"&#39;", 24'h0};
    localparam logic [63:0] ENT_LT   = {"&lt;", 32'h0};
    localparam logic [63:0] ENT_GT   = {"&gt;", 32'h0};
    localparam logic [63:0] ENT_AMP  = {"&amp;", 24'h0};

    // queue depth between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = 2;
    localparam int QCNT_W      = 3;

    // how the body of one transaction is written out
    typedef enum logic [2:0] {
        K_NONE,
        K_RAW,
        K_TWO,
        K_HEX,
        K_ENT,
        K_SEP
    } t_kind;

    // one classified input transaction
    typedef struct packed {
        logic [1:0] pre;
        t_kind      kind;
        logic [7:0] ch;
        logic       last;
    } t_desc;

    // uppercase hex digit
    function automatic logic [7:0] hex_char(input logic [3:0] d);
        logic [7:0] r;
        if (d < 4'd10) begin
            r = 8'(C_DIG0 + {4'h0, d});
        end else begin
            r = 8'(C_UPPER_A + {4'h0, d} - 8'd10);
        end
        return r;
    endfunction

    // body text of a transaction, left aligned in eight bytes
    function automatic logic [63:0] body_text(input t_kind kind, input logic [7:0] ch);
        logic [63:0] r;
        r = 64'h0;
        unique case (kind)
            K_NONE: r = 64'h0;
            K_RAW:  r = {ch, 56'h0};
            K_TWO:  r = {C_BSLASH, ch, 48'h0};
            K_HEX:  r = {C_BSLASH, C_LOW_U, C_DIG0, C_DIG0,
                         hex_char(ch[7:4]), hex_char(ch[3:0]), 16'h0};
            K_SEP:  r = {C_BSLASH, C_LOW_U, C_DIG2, C_DIG0, C_DIG2,
                         (ch == C_UTF_A9) ? C_DIG9 : C_DIG8, 16'h0};
            K_ENT: begin
                case (ch)
                    C_QUOTE: r = ENT_QUOT;
                    C_APOS:  r = ENT_APOS;
                    C_LT:    r = ENT_LT;
                    C_GT:    r = ENT_GT;
                    default: r = ENT_AMP;
                endcase
            end
            default: r = 64'h0;
        endcase
        return r;
    endfunction

    // body length in bytes
    function automatic logic [3:0] body_len(input t_kind kind, input logic [7:0] ch);
        logic [3:0] r;
        r = 4'd0;
        unique case (kind)
            K_NONE: r = 4'd0;
            K_RAW:  r = 4'd1;
            K_TWO:  r = 4'd2;
            K_HEX:  r = 4'd6;
            K_SEP:  r = 4'd6;
            K_ENT: begin
                case (ch)
                    C_QUOTE: r = 4'd6;
                    C_APOS:  r = 4'd5;
                    C_LT:    r = 4'd4;
                    C_GT:    r = 4'd4;
                    default: r = 4'd5;
                endcase
            end
            default: r = 4'd0;
        endcase
        return r;
    endfunction

endpackage

### hw/rtl/json_string_escaper_top.sv
// json_string_escaper_top: top level of the json string escaper; holds the
// configuration registers and ties front, queue and back. Depends on jse_pkg.

// Escapes the bytes of one string, one input transaction per byte, into
// JSON text. An input byte is taken on every cycle while full is low; the
// front classifies it in that cycle and places a descriptor in a four-entry
// queue, so the input stalls only when the queue is full. The back emits one
// output byte per cycle while the result register is empty or popped, and a
// byte that expands gives as many output bytes as its escape has (two for
// \n style escapes, four to six for entities, six for \u00XX and \u2028);
// that sequencer is what sets the sustained rate. The descriptor of a
// transaction is registered in the queue, then its first output byte in the
// result register. A leading E2 or E2 80 of a UTF-8 line separator is held
// with no output until the next byte or the end of the string decides it.
// Configuration must be written through i_cfg_we only while the block is idle; the block itself does not enforce it.

module json_string_escaper_top (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic [1:0] i_cfg_idx,
    input  logic [1:0] i_cfg_data,
    input  logic       push,
    output logic       full,
    input  logic [7:0] i_in_byte,
    input  logic       i_last_byte,
    output logic       empty,
    input  logic       pop,
    output logic [7:0] o_out_byte,
    output logic       o_last_of_run,
    output logic       o_end_of_string
);

    logic [1:0]     r_escape_mode;
    logic           r_line_sep;
    logic           in_acc;
    logic           q_wr;
    jse_pkg::t_desc q_wdesc;
    logic           q_rd;
    logic           q_valid;
    jse_pkg::t_desc q_rdesc;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_escape_mode <= jse_pkg::MODE_PLAIN;
            r_line_sep    <= 1'b1;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                jse_pkg::REG_ESCAPE_MODE: r_escape_mode <= i_cfg_data;
                jse_pkg::REG_LINE_SEP:    r_line_sep    <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    assign in_acc = push && !full;

    // front classifier
    jse_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_accept   (in_acc),
        .i_byte     (i_in_byte),
        .i_last     (i_last_byte),
        .i_mode     (r_escape_mode),
        .i_line_sep (r_line_sep),
        .o_push     (q_wr),
        .o_desc     (q_wdesc)
    );

    // descriptor queue
    jse_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (q_wr),
        .i_desc  (q_wdesc),
        .i_rd    (q_rd),
        .o_full  (full),
        .o_valid (q_valid),
        .o_desc  (q_rdesc)
    );

    // back sequencer and result register
    jse_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (q_valid),
        .i_desc          (q_rdesc),
        .o_rd            (q_rd),
        .i_pop           (pop),
        .o_empty         (empty),
        .o_out_byte      (o_out_byte),
        .o_last_of_run   (o_last_of_run),
        .o_end_of_string (o_end_of_string)
    );

endmodule

### hw/rtl/jse_front.sv
// jse_front: classifies each accepted input byte into an output descriptor
// and tracks the held UTF-8 line separator prefix. Depends on jse_pkg.

module jse_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_accept,
    input  logic [7:0]     i_byte,
    input  logic           i_last,
    input  logic [1:0]     i_mode,
    input  logic           i_line_sep,
    output logic           o_push,
    output jse_pkg::t_desc o_desc
);

    logic [1:0]     r_held;
    logic [1:0]     n_held;
    logic [1:0]     pre;
    logic           fresh;
    logic           hold_new;
    logic           sep_hit;
    jse_pkg::t_kind e_kind;
    logic [7:0]     e_ch;
    jse_pkg::t_kind kind;
    logic [7:0]     ch;

    // escape classification of a single byte
    always_comb begin
        e_kind = jse_pkg::K_RAW;
        e_ch   = i_byte;
        if (i_mode == jse_pkg::MODE_HTML &&
            (i_byte == jse_pkg::C_QUOTE || i_byte == jse_pkg::C_APOS ||
             i_byte == jse_pkg::C_LT || i_byte == jse_pkg::C_GT ||
             i_byte == jse_pkg::C_AMP)) begin
            e_kind = jse_pkg::K_ENT;
        end else if (i_mode == jse_pkg::MODE_RELAXED && i_byte == jse_pkg::C_SLASH) begin
            e_kind = jse_pkg::K_RAW;
        end else if (i_mode != jse_pkg::MODE_UNSAFE && i_byte == jse_pkg::C_SLASH) begin
            e_kind = jse_pkg::K_TWO;
        end else if (i_mode != jse_pkg::MODE_UNSAFE &&
                     (i_byte == jse_pkg::C_LT || i_byte == jse_pkg::C_GT ||
                      i_byte == jse_pkg::C_APOS)) begin
            e_kind = jse_pkg::K_HEX;
        end else begin
            unique case (i_byte)
                jse_pkg::C_QUOTE:  e_kind = jse_pkg::K_TWO;
                jse_pkg::C_BSLASH: e_kind = jse_pkg::K_TWO;
                jse_pkg::C_BS: begin
                    e_kind = jse_pkg::K_TWO;
                    e_ch   = jse_pkg::C_LOW_B;
                end
                jse_pkg::C_FF: begin
                    e_kind = jse_pkg::K_TWO;
                    e_ch   = jse_pkg::C_LOW_F;
                end
                jse_pkg::C_LF: begin
                    e_kind = jse_pkg::K_TWO;
                    e_ch   = jse_pkg::C_LOW_N;
                end
                jse_pkg::C_CR: begin
                    e_kind = jse_pkg::K_TWO;
                    e_ch   = jse_pkg::C_LOW_R;
                end
                jse_pkg::C_TAB: begin
                    e_kind = jse_pkg::K_TWO;
                    e_ch   = jse_pkg::C_LOW_T;
                end
                default: begin
                    e_kind = (i_byte < jse_pkg::C_SPACE) ? jse_pkg::K_HEX : jse_pkg::K_RAW;
                end
            endcase
        end
    end

    // prefix matching and release of held bytes
    always_comb begin
        pre     = jse_pkg::HELD_NONE;
        fresh   = 1'b1;
        sep_hit = 1'b0;
        if (!i_line_sep) begin
            pre = r_held;
        end else begin
            case (r_held)
                jse_pkg::HELD_E280: begin
                    if (i_byte == jse_pkg::C_UTF_A8 || i_byte == jse_pkg::C_UTF_A9) begin
                        sep_hit = 1'b1;
                        fresh   = 1'b0;
                    end else begin
                        pre = jse_pkg::HELD_E280;
                    end
                end
                jse_pkg::HELD_E2: begin
                    if (i_byte == jse_pkg::C_UTF_80 && !i_last) begin
                        fresh = 1'b0;
                    end else begin
                        pre = jse_pkg::HELD_E2;
                    end
                end
                default: pre = jse_pkg::HELD_NONE;
            endcase
        end
        hold_new = i_line_sep && fresh && i_byte == jse_pkg::C_UTF_E2 && !i_last;

        if (hold_new) begin
            n_held = jse_pkg::HELD_E2;
        end else if (fresh || sep_hit) begin
            n_held = jse_pkg::HELD_NONE;
        end else begin
            n_held = jse_pkg::HELD_E280;
        end

        if (sep_hit) begin
            kind = jse_pkg::K_SEP;
            ch   = i_byte;
        end else if (fresh && !hold_new) begin
            kind = e_kind;
            ch   = e_ch;
        end else begin
            kind = jse_pkg::K_NONE;
            ch   = i_byte;
        end
    end

    assign o_push      = i_accept && (pre != jse_pkg::HELD_NONE || kind != jse_pkg::K_NONE);
    assign o_desc.pre  = pre;
    assign o_desc.kind = kind;
    assign o_desc.ch   = ch;
    assign o_desc.last = i_last;

    // held prefix state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held <= jse_pkg::HELD_NONE;
        end else if (i_accept) begin
            r_held <= n_held;
        end
    end

`ifndef SYNTHESIS
    a_held_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_held != 2'd3)
        else $error("held prefix count out of range");
`endif

endmodule

### hw/rtl/jse_queue.sv
// jse_queue: short descriptor queue between the front classifier and the
// back sequencer. Depends on jse_pkg.

module jse_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_wr,
    input  jse_pkg::t_desc i_desc,
    input  logic           i_rd,
    output logic           o_full,
    output logic           o_valid,
    output jse_pkg::t_desc o_desc
);

    jse_pkg::t_desc                r_mem [jse_pkg::QUEUE_DEPTH];
    logic [jse_pkg::QPTR_W-1:0]    r_wp;
    logic [jse_pkg::QPTR_W-1:0]    r_rp;
    logic [jse_pkg::QCNT_W-1:0]    r_cnt;

    assign o_full  = (r_cnt == jse_pkg::QCNT_W'(jse_pkg::QUEUE_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_desc  = r_mem[r_rp];

    // storage
    always_ff @(posedge i_clk) begin
        if (i_wr) begin
            r_mem[r_wp] <= i_desc;
        end
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_wr) begin
                r_wp <= r_wp + 1'b1;
            end
            if (i_rd) begin
                r_rp <= r_rp + 1'b1;
            end
            if (i_wr && !i_rd) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (!i_wr && i_rd) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= jse_pkg::QCNT_W'(jse_pkg::QUEUE_DEPTH))
        else $error("descriptor queue over its depth");
    a_ptr_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == '0 || r_cnt == jse_pkg::QCNT_W'(jse_pkg::QUEUE_DEPTH)) |-> r_wp == r_rp)
        else $error("queue pointers disagree with fill count");
`endif

endmodule

### hw/rtl/jse_back.sv
// jse_back: walks each queued descriptor one output byte per cycle into the
// result register while it is empty or popped. Depends on jse_pkg.

module jse_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    input  jse_pkg::t_desc i_desc,
    output logic           o_rd,
    input  logic           i_pop,
    output logic           o_empty,
    output logic [7:0]     o_out_byte,
    output logic           o_last_of_run,
    output logic           o_end_of_string
);

    logic [2:0]  r_idx;
    logic        r_ov;
    logic [7:0]  r_byte;
    logic        r_lrun;
    logic        r_eos;
    logic        load;
    logic        run_end;
    logic [3:0]  run_len;
    logic [2:0]  body_idx;
    logic [63:0] body;
    logic [63:0] shifted;
    logic [7:0]  cur_byte;

    assign load    = i_valid && (!r_ov || i_pop);
    assign run_len = {2'b00, i_desc.pre} + jse_pkg::body_len(i_desc.kind, i_desc.ch);
    assign run_end = ({1'b0, r_idx} == run_len - 4'd1);
    assign o_rd    = load && run_end;

    // current byte: released prefix first, then the body text
    always_comb begin
        body     = jse_pkg::body_text(i_desc.kind, i_desc.ch);
        body_idx = r_idx - {1'b0, i_desc.pre};
        shifted  = body >> {3'd7 - body_idx, 3'b000};
        if (r_idx < {1'b0, i_desc.pre}) begin
            cur_byte = (r_idx == 3'd0) ? jse_pkg::C_UTF_E2 : jse_pkg::C_UTF_80;
        end else begin
            cur_byte = shifted[7:0];
        end
    end

    // byte counter within the run
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx <= '0;
        end else if (load) begin
            r_idx <= run_end ? 3'd0 : r_idx + 3'd1;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (load) begin
            r_ov <= 1'b1;
        end else if (i_pop) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_byte <= cur_byte;
            r_lrun <= run_end;
            r_eos  <= run_end && i_desc.last;
        end
    end

    assign o_empty         = !r_ov;
    assign o_out_byte      = r_byte;
    assign o_last_of_run   = r_lrun;
    assign o_end_of_string = r_eos;

`ifndef SYNTHESIS
    a_eos_ends_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && r_eos) |-> r_lrun)
        else $error("end of string without end of run");
    a_run_keeps_desc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_idx != 3'd0) |-> i_valid)
        else $error("run in progress lost its descriptor");
`endif

endmodule

### dv/json_string_escaper_top_tb.sv
// json_string_escaper_top_tb: self-checking testbench for the json string escaper.
// Drives raw string bytes, predicts the escaped text per byte and checks every
// output transaction in order. Depends on jse_pkg and json_string_escaper_top.

module json_string_escaper_top_tb;

    // indexes past the last register, writes there must change nothing
    localparam logic [1:0] REG_SPARE_A = 2'd2;
    localparam logic [1:0] REG_SPARE_B = 2'd3;

    localparam int PHASES       = 8;
    localparam int HALF_PHASE   = 19;
    localparam int DRAIN_CYCLES = 10;
    localparam int TIMEOUT      = 12 * 400000;

    // per phase register settings, extremes included
    localparam logic [1:0] PHASE_MODE [PHASES] = '{jse_pkg::MODE_PLAIN, jse_pkg::MODE_HTML,
        jse_pkg::MODE_RELAXED, jse_pkg::MODE_UNSAFE, jse_pkg::MODE_HTML, jse_pkg::MODE_PLAIN,
        jse_pkg::MODE_UNSAFE, jse_pkg::MODE_RELAXED};
    localparam logic PHASE_SEP [PHASES] = '{1'b1, 1'b1, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 1'b1};

    // bytes that some mode escapes
    localparam logic [7:0] SPECIALS [14] = '{jse_pkg::C_QUOTE, jse_pkg::C_APOS,
        jse_pkg::C_LT, jse_pkg::C_GT, jse_pkg::C_AMP, jse_pkg::C_SLASH, jse_pkg::C_BSLASH,
        jse_pkg::C_BS, jse_pkg::C_TAB, jse_pkg::C_LF, jse_pkg::C_FF, jse_pkg::C_CR,
        8'h00, 8'h1F};

    typedef struct packed {
        logic [7:0] ch;
        logic       last;
    } t_raw_byte;

    typedef struct packed {
        logic [7:0] ch;
        logic       run_end;
        logic       str_end;
    } t_esc_byte;

    logic       i_clk       = 1'b0;
    logic       i_rst_n     = 1'b0;
    logic       i_cfg_we    = 1'b0;
    logic [1:0] i_cfg_idx   = 2'd0;
    logic [1:0] i_cfg_data  = 2'd0;
    logic       push        = 1'b0;
    logic       full;
    logic [7:0] i_in_byte   = 8'd0;
    logic       i_last_byte = 1'b0;
    logic       empty;
    logic       pop         = 1'b0;
    logic [7:0] o_out_byte;
    logic       o_last_of_run;
    logic       o_end_of_string;

    // predictor copy of configuration and held prefix
    logic [1:0] cfg_mode  = jse_pkg::MODE_PLAIN;
    logic       cfg_sep   = 1'b1;
    logic [1:0] held_cnt  = jse_pkg::HELD_NONE;

    t_raw_byte  pending_bytes[$];
    t_esc_byte  expected_text[$];
    logic [7:0] run_bytes[$];
    string      hex_digits = "0123456789ABCDEF";

    int send_idle_pct = 0;
    int stall_pct     = 0;
    int n_errors      = 0;
    int n_in          = 0;
    int n_out         = 0;
    int n_queued      = 0;
    int n_settings    = 0;

    t_raw_byte next_byte;
    t_esc_byte got_byte;
    t_esc_byte want_byte;

    json_string_escaper_top uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_data      (i_cfg_data),
        .push            (push),
        .full            (full),
        .i_in_byte       (i_in_byte),
        .i_last_byte     (i_last_byte),
        .empty           (empty),
        .pop             (pop),
        .o_out_byte      (o_out_byte),
        .o_last_of_run   (o_last_of_run),
        .o_end_of_string (o_end_of_string)
    );

    // clock
    always #6 i_clk = ~i_clk;

    // escaped text building
    task automatic add_byte(input logic [7:0] b);
        run_bytes.insert(run_bytes.size(), b);
    endtask

    task automatic put_str(input string s);
        for (int i = 0; i < s.len(); i++) begin
            add_byte(s[i]);
        end
    endtask

    task automatic put_hex(input logic [7:0] c);
        put_str("\\u00");
        add_byte(hex_digits[c[7:4]]);
        add_byte(hex_digits[c[3:0]]);
    endtask

    task automatic release_prefix();
        if (held_cnt != jse_pkg::HELD_NONE) begin
            add_byte(jse_pkg::C_UTF_E2);
        end
        if (held_cnt == jse_pkg::HELD_E280) begin
            add_byte(jse_pkg::C_UTF_80);
        end
        held_cnt = jse_pkg::HELD_NONE;
    endtask

    // escape one byte under the current mode
    task automatic escape_char(input logic [7:0] c);
        logic is_html_char;
        is_html_char = (c == jse_pkg::C_QUOTE) || (c == jse_pkg::C_APOS) ||
                       (c == jse_pkg::C_LT) || (c == jse_pkg::C_GT) || (c == jse_pkg::C_AMP);
        if (cfg_mode == jse_pkg::MODE_HTML && is_html_char) begin
            case (c)
                jse_pkg::C_QUOTE: put_str("&quot;");
                jse_pkg::C_APOS:  put_str("&#39;");
                jse_pkg::C_LT:    put_str("&lt;");
                jse_pkg::C_GT:    put_str("&gt;");
                default:          put_str("&amp;");
            endcase
        end else if (cfg_mode == jse_pkg::MODE_RELAXED && c == jse_pkg::C_SLASH) begin
            add_byte(c);
        end else if (cfg_mode != jse_pkg::MODE_UNSAFE && c == jse_pkg::C_SLASH) begin
            put_str("\\/");
        end else if (cfg_mode != jse_pkg::MODE_UNSAFE &&
                     (c == jse_pkg::C_LT || c == jse_pkg::C_GT || c == jse_pkg::C_APOS)) begin
            put_hex(c);
        end else if (c == jse_pkg::C_QUOTE) begin
            put_str("\\\"");
        end else if (c == jse_pkg::C_BSLASH) begin
            put_str("\\\\");
        end else if (c == jse_pkg::C_BS) begin
            put_str("\\b");
        end else if (c == jse_pkg::C_FF) begin
            put_str("\\f");
        end else if (c == jse_pkg::C_LF) begin
            put_str("\\n");
        end else if (c == jse_pkg::C_CR) begin
            put_str("\\r");
        end else if (c == jse_pkg::C_TAB) begin
            put_str("\\t");
        end else if (c < jse_pkg::C_SPACE) begin
            put_hex(c);
        end else begin
            add_byte(c);
        end
    endtask

    // expected output run for one accepted input byte
    task automatic escape_input_byte(input logic [7:0] c, input logic last);
        logic      done;
        t_esc_byte e;
        run_bytes.delete();
        done = 1'b0;
        if (!cfg_sep) begin
            release_prefix();
            escape_char(c);
        end else begin
            if (held_cnt == jse_pkg::HELD_E280) begin
                if (c == jse_pkg::C_UTF_A8 || c == jse_pkg::C_UTF_A9) begin
                    held_cnt = jse_pkg::HELD_NONE;
                    if (c == jse_pkg::C_UTF_A9) begin
                        put_str("\\u2029");
                    end else begin
                        put_str("\\u2028");
                    end
                    done = 1'b1;
                end else begin
                    release_prefix();
                end
            end else if (held_cnt == jse_pkg::HELD_E2) begin
                if (c == jse_pkg::C_UTF_80 && !last) begin
                    held_cnt = jse_pkg::HELD_E280;
                    done = 1'b1;
                end else begin
                    release_prefix();
                end
            end
            // a failed match leaves the byte to start over
            if (!done) begin
                if (c == jse_pkg::C_UTF_E2 && !last) begin
                    held_cnt = jse_pkg::HELD_E2;
                end else begin
                    escape_char(c);
                end
            end
        end
        if (last) begin
            release_prefix();
        end
        foreach (run_bytes[k]) begin
            e.ch      = run_bytes[k];
            e.run_end = (k == run_bytes.size() - 1);
            e.str_end = last && (k == run_bytes.size() - 1);
            expected_text.insert(expected_text.size(), e);
        end
    endtask

    task automatic report_mismatch(input string what, input t_esc_byte got,
                                   input t_esc_byte want);
        n_errors++;
        $display("mismatch at output %0d: %s, got %h/%b/%b want %h/%b/%b", n_out, what,
                 got.ch, got.run_end, got.str_end, want.ch, want.run_end, want.str_end);
    endtask

    // driver: one input transaction per accepted push
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            push <= 1'b0;
        end else begin
            if (push && !full) begin
                escape_input_byte(i_in_byte, i_last_byte);
                n_in++;
            end
            if (!push || !full) begin
                if (pending_bytes.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                    next_byte = pending_bytes.pop_front();
                    push        <= 1'b1;
                    i_in_byte   <= next_byte.ch;
                    i_last_byte <= next_byte.last;
                end else begin
                    push <= 1'b0;
                end
            end
        end
    end

    // monitor: check each popped output transaction against the oldest expectation
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            pop <= 1'b0;
        end else begin
            if (pop && !empty) begin
                got_byte = '{o_out_byte, o_last_of_run, o_end_of_string};
                if (expected_text.size() == 0) begin
                    report_mismatch("output with nothing expected", got_byte, '0);
                end else begin
                    want_byte = expected_text.pop_front();
                    if (got_byte != want_byte) begin
                        report_mismatch("wrong field", got_byte, want_byte);
                    end
                end
                n_out++;
            end
            pop <= ($urandom_range(99) >= stall_pct);
        end
    end

    task automatic queue_byte(input logic [7:0] c, input logic last);
        pending_bytes.insert(pending_bytes.size(), '{c, last});
        n_queued++;
    endtask

    // random string, mostly escapable bytes and separator sequences
    task automatic queue_string();
        logic [7:0] txt[$];
        int         len;
        int         r;
        len = $urandom_range(1, 8);
        while (txt.size() < len) begin
            r = $urandom_range(99);
            if (r < 35) begin
                txt.insert(txt.size(), SPECIALS[$urandom_range(13)]);
            end else if (r < 45) begin
                txt.insert(txt.size(), 8'($urandom_range(31)));
            end else if (r < 65) begin
                txt.insert(txt.size(), jse_pkg::C_UTF_E2);
                case ($urandom_range(5))
                    0: begin
                        txt.insert(txt.size(), jse_pkg::C_UTF_80);
                        txt.insert(txt.size(), jse_pkg::C_UTF_A8);
                    end
                    1: begin
                        txt.insert(txt.size(), jse_pkg::C_UTF_80);
                        txt.insert(txt.size(), jse_pkg::C_UTF_A9);
                    end
                    2: begin
                        txt.insert(txt.size(), jse_pkg::C_UTF_80);
                    end
                    3: begin
                        txt.insert(txt.size(), jse_pkg::C_UTF_80);
                        txt.insert(txt.size(), 8'($urandom_range(255)));
                    end
                    4: begin
                        txt.insert(txt.size(), 8'($urandom_range(255)));
                    end
                    default: begin
                    end
                endcase
            end else begin
                txt.insert(txt.size(), 8'($urandom_range(255)));
            end
        end
        foreach (txt[i]) begin
            queue_byte(txt[i], i == txt.size() - 1);
        end
    endtask

    // wait until every expected transaction arrived and the pipe has settled
    task automatic wait_drained();
        while (pending_bytes.size() > 0 || push || expected_text.size() > 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [1:0] data);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == jse_pkg::REG_ESCAPE_MODE) begin
            cfg_mode = data;
        end else if (idx == jse_pkg::REG_LINE_SEP) begin
            cfg_sep = data[0];
        end
    endtask

    // run length guard
    initial begin
        #(TIMEOUT);
        $display("tb: failure");
        $finish;
    end

    // stimulus sequence
    initial begin
        int start;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: every escape under reset settings, separators and broken prefixes
        send_idle_pct = 33;
        stall_pct     = 33;
        n_settings    = 1;
        foreach (SPECIALS[i]) begin
            queue_byte(SPECIALS[i], 1'b0);
        end
        queue_byte(8'hFF, 1'b1);
        queue_byte(jse_pkg::C_UTF_E2, 1'b0);
        queue_byte(jse_pkg::C_UTF_80, 1'b0);
        queue_byte(jse_pkg::C_UTF_A8, 1'b0);
        queue_byte(jse_pkg::C_UTF_E2, 1'b0);
        queue_byte(jse_pkg::C_UTF_80, 1'b0);
        queue_byte(jse_pkg::C_UTF_A9, 1'b1);
        // failed match where the byte begins a new prefix
        queue_byte(jse_pkg::C_UTF_E2, 1'b0);
        queue_byte(jse_pkg::C_UTF_E2, 1'b0);
        queue_byte(jse_pkg::C_UTF_80, 1'b0);
        queue_byte(jse_pkg::C_UPPER_A, 1'b0);
        // prefixes cut off by the end of the string
        queue_byte(jse_pkg::C_UTF_E2, 1'b0);
        queue_byte(jse_pkg::C_UTF_80, 1'b1);
        queue_byte(jse_pkg::C_UTF_E2, 1'b1);
        // leave a prefix held across a register write
        queue_byte(jse_pkg::C_UTF_E2, 1'b0);
        queue_byte(jse_pkg::C_UTF_80, 1'b0);
        wait_drained();

        // separators off while held, upper data bit is ignored
        write_reg(jse_pkg::REG_LINE_SEP, 2'b10);
        queue_byte(jse_pkg::C_UPPER_A, 1'b1);
        wait_drained();
        write_reg(REG_SPARE_A, 2'b11);
        write_reg(REG_SPARE_B, 2'b01);

        // random phases across settings and idling patterns
        for (int p = 0; p < PHASES; p++) begin
            wait_drained();
            write_reg(jse_pkg::REG_ESCAPE_MODE, PHASE_MODE[p]);
            write_reg(jse_pkg::REG_LINE_SEP, {1'($urandom_range(1)), PHASE_SEP[p]});
            n_settings++;
            case (p % 4)
                0: begin
                    send_idle_pct = 0;
                    stall_pct     = 0;
                end
                1: begin
                    send_idle_pct = 84;
                    stall_pct     = 0;
                end
                2: begin
                    send_idle_pct = 0;
                    stall_pct     = 84;
                end
                default: begin
                    send_idle_pct = 33;
                    stall_pct     = 33;
                end
            endcase
            for (int half = 0; half < 2; half++) begin
                start = n_queued;
                while (n_queued - start < HALF_PHASE) begin
                    queue_string();
                end
                // sender holds off until the output side has caught up
                if (half == 0) begin
                    wait_drained();
                end
            end
            // sometimes carry a held prefix into the next setting
            if ($urandom_range(1)) begin
                queue_byte(jse_pkg::C_UTF_E2, 1'b0);
                if ($urandom_range(1)) begin
                    queue_byte(jse_pkg::C_UTF_80, 1'b0);
                end
            end
        end
        wait_drained();

        $display("tb: %0d input bytes, %0d output bytes checked over %0d register settings",
                 n_in, n_out, n_settings);
        $display("tb: modes plain/html/relaxed/unsafe, separators on and off, idling mixed");
        if (n_errors == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

### files.f
hw/rtl/jse_pkg.sv
hw/rtl/jse_front.sv
hw/rtl/jse_queue.sv
hw/rtl/jse_back.sv
hw/rtl/json_string_escaper_top.sv
dv/json_string_escaper_top_tb.sv
